[rtl/rgsp_pkg.sv]
// rgsp_pkg: shared widths, register codes, band codes and item types
// for the gap speed planner; no dependencies

package rgsp_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int SPEED_W    = 16;
  localparam int GAP_W      = 20;
  localparam int BAND_W     = 3;
  localparam int REG_W      = 12;
  localparam int CAP_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // product and magnitude widths
  localparam int PROD_RV_W  = REG_W + SPEED_W;
  localparam int PROD_RA_W  = 2 * REG_W;
  localparam int PROD_RAR_W = 3 * REG_W;
  localparam int CLOSE_W    = SPEED_W + 1;
  localparam int DVS_W      = REG_W + 1;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRAKE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRAKE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CAP     = 3'd4;

  localparam logic [REG_W-1:0] RST_RESPONSE_TIME = 12'd256;
  localparam logic [REG_W-1:0] RST_MAX_ACCEL     = 12'd512;
  localparam logic [REG_W-1:0] RST_MIN_BRAKE     = 12'd1024;
  localparam logic [REG_W-1:0] RST_MAX_BRAKE     = 12'd2048;
  localparam logic [CAP_W-1:0] RST_SPEED_CAP     = 16'd7680;

  localparam logic [BAND_W-1:0] BAND_NO_LEAD = 3'd0;
  localparam logic [BAND_W-1:0] BAND_SAFE    = 3'd1;
  localparam logic [BAND_W-1:0] BAND_HOLD    = 3'd2;
  localparam logic [BAND_W-1:0] BAND_BRAKE   = 3'd3;
  localparam logic [BAND_W-1:0] BAND_WARN    = 3'd4;
  localparam logic [BAND_W-1:0] BAND_EMERG   = 3'd5;

  typedef struct packed {
    logic [SPEED_W-1:0]        own_speed;
    logic signed [SPEED_W-1:0] lead_rel_speed;
    logic [GAP_W-1:0]          lead_gap;
    logic                      lead_present;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] target_speed;
    logic [GAP_W-1:0]   safe_gap;
    logic [BAND_W-1:0]  band;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] response_time;
    logic [REG_W-1:0] max_accel;
    logic [REG_W-1:0] min_brake;
    logic [REG_W-1:0] max_brake;
    logic [CAP_W-1:0] speed_cap;
  } cfg_regs_t;

  // width of the speed after the response interval
  function automatic int resp_speed_width(int frac);
    int a;
    a = PROD_RA_W - frac;
    return ((a > SPEED_W) ? a : SPEED_W) + 1;
  endfunction

  // dividend and quotient width of both braking terms, always even
  function automatic int quot_width(int frac);
    int w2;
    w2 = 2 * resp_speed_width(frac);
    return (w2 > 2 * CLOSE_W) ? w2 : 2 * CLOSE_W;
  endfunction

endpackage

[rtl/rgsp_stream_if.sv]
// rgsp_stream_if: valid/ready stream channel with a typed payload
// no dependencies

interface rgsp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/rss_gap_speed_planner_unit.sv]
// rss_gap_speed_planner_unit: top level of the rss gap speed planner
// depends on rgsp_pkg, rgsp_stream_if, rgsp_term_calc, rgsp_div_pipe, rgsp_band_sel
// throughput: one request per cycle while out_s takes results; every
// stage holds its own valid bit, so bubbles close up and new requests
// enter while a finished result waits
// reset: synchronous active-low rst_n clears all valid bits and loads the
// register defaults; no clearing pass, the block is ready right after reset

module rss_gap_speed_planner_unit import rgsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rgsp_stream_if.sink           in_s,
  rgsp_stream_if.source         out_s
);

  localparam int QW     = quot_width(FRAC_BITS);
  localparam int SUM_W  = QW + 2;
  localparam int SIDE_W = SUM_W + SPEED_W + GAP_W + 1;

  // configuration registers; the user must write them only while the pipe is empty, the block does not enforce it
  cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_time <= RST_RESPONSE_TIME;
      cfg_r.max_accel     <= RST_MAX_ACCEL;
      cfg_r.min_brake     <= RST_MIN_BRAKE;
      cfg_r.max_brake     <= RST_MAX_BRAKE;
      cfg_r.speed_cap     <= RST_SPEED_CAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESPONSE_TIME: cfg_r.response_time <= cfg_data[REG_W-1:0];
        CFG_MAX_ACCEL:     cfg_r.max_accel     <= cfg_data[REG_W-1:0];
        CFG_MIN_BRAKE:     cfg_r.min_brake     <= cfg_data[REG_W-1:0];
        CFG_MAX_BRAKE:     cfg_r.max_brake     <= cfg_data[REG_W-1:0];
        CFG_SPEED_CAP:     cfg_r.speed_cap     <= cfg_data[CAP_W-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // braking divisors are twice the deceleration, zero treated as one
  logic [DVS_W-1:0] divisor [2];
  assign divisor[0] = {((cfg_r.min_brake == '0) ? REG_W'(1) : cfg_r.min_brake), 1'b0};
  assign divisor[1] = {((cfg_r.max_brake == '0) ? REG_W'(1) : cfg_r.max_brake), 1'b0};

  // front end: reaction travel, speed after response, squared speeds
  logic               tc_valid, tc_ready;
  logic [QW-1:0]      tc_ego_sq, tc_close_sq;
  logic [SUM_W-1:0]   tc_pos;
  logic [SPEED_W-1:0] tc_speed;
  logic [GAP_W-1:0]   tc_gap;
  logic               tc_present;

  rgsp_term_calc #(
    .FRAC_BITS (FRAC_BITS)
  ) u_term (
    .clk         (clk),
    .rst_n       (rst_n),
    .resp_time   (cfg_r.response_time),
    .max_accel   (cfg_r.max_accel),
    .up_valid    (in_s.valid),
    .up_ready    (in_s.ready),
    .up_item     (in_s.payload),
    .dn_valid    (tc_valid),
    .dn_ready    (tc_ready),
    .dn_ego_sq   (tc_ego_sq),
    .dn_close_sq (tc_close_sq),
    .dn_pos      (tc_pos),
    .dn_speed    (tc_speed),
    .dn_gap      (tc_gap),
    .dn_present  (tc_present)
  );

  // divider: lane 0 ego braking distance, lane 1 lead braking distance
  logic [QW-1:0]     dv_dividend [2];
  logic [QW-1:0]     dv_quot     [2];
  logic [SIDE_W-1:0] dv_side_in, dv_side_out;
  logic              dv_valid, dv_ready;

  assign dv_dividend[0] = tc_ego_sq;
  assign dv_dividend[1] = tc_close_sq;
  assign dv_side_in     = {tc_pos, tc_speed, tc_gap, tc_present};

  rgsp_div_pipe #(
    .QW     (QW),
    .DW     (DVS_W),
    .LANES  (2),
    .STEP   (DIV_STEP),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .divisor  (divisor),
    .up_valid (tc_valid),
    .up_ready (tc_ready),
    .dividend (dv_dividend),
    .up_side  (dv_side_in),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .quotient (dv_quot),
    .dn_side  (dv_side_out)
  );

  // side data unpacked in the order it was packed
  logic [SUM_W-1:0]   dv_pos;
  logic [SPEED_W-1:0] dv_speed;
  logic [GAP_W-1:0]   dv_gap;
  logic               dv_present;

  assign {dv_pos, dv_speed, dv_gap, dv_present} = dv_side_out;

  // back end: safe gap clamp, band pick, set speed; last stage is the output register
  rgsp_band_sel #(
    .FRAC_BITS (FRAC_BITS)
  ) u_band (
    .clk       (clk),
    .rst_n     (rst_n),
    .speed_cap (cfg_r.speed_cap),
    .up_valid  (dv_valid),
    .up_ready  (dv_ready),
    .ego_brk   (dv_quot[0]),
    .lead_brk  (dv_quot[1]),
    .pos       (dv_pos),
    .speed     (dv_speed),
    .gap       (dv_gap),
    .present   (dv_present),
    .dn_valid  (out_s.valid),
    .dn_ready  (out_s.ready),
    .dn_item   (out_s.payload)
  );

  // checks on the result stream
  localparam logic [GAP_W-1:0] FLOOR_CHK = GAP_W'(5 << FRAC_BITS);

  a_no_lead_zero_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.payload.band == BAND_NO_LEAD |-> out_s.payload.safe_gap == '0)
    else $error("no-lead result carries a nonzero safe gap");

  a_lead_gap_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.payload.band != BAND_NO_LEAD |-> out_s.payload.safe_gap >= FLOOR_CHK)
    else $error("safe gap below the five meter floor");

  a_speed_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> out_s.payload.target_speed <= cfg_r.speed_cap)
    else $error("set speed above the speed cap");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_s.valid)
    else $error("result valid right after reset");

endmodule

[rtl/rgsp_term_calc.sv]
// rgsp_term_calc: three pipeline stages forming the reaction terms and the
// squared speeds fed to the divider; depends on rgsp_pkg

module rgsp_term_calc import rgsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [REG_W-1:0]               resp_time,
  input  logic [REG_W-1:0]               max_accel,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  in_item_t                       up_item,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output logic [quot_width(FRAC_BITS)-1:0]   dn_ego_sq,
  output logic [quot_width(FRAC_BITS)-1:0]   dn_close_sq,
  output logic [quot_width(FRAC_BITS)+1:0]   dn_pos,
  output logic [SPEED_W-1:0]             dn_speed,
  output logic [GAP_W-1:0]               dn_gap,
  output logic                           dn_present
);

  localparam int W_W   = resp_speed_width(FRAC_BITS);
  localparam int QW    = quot_width(FRAC_BITS);
  localparam int SUM_W = QW + 2;

  logic en1, en2, en3;

  // stage 1: first products and closing speed magnitude
  logic signed [SPEED_W+1:0] close;
  logic [CLOSE_W-1:0]        close_mag;
  logic                      s1_v_r;
  logic [PROD_RV_W-1:0]      s1_rv_r;
  logic [PROD_RA_W-1:0]      s1_ra_r;
  logic [CLOSE_W-1:0]        s1_cm_r;
  logic [SPEED_W-1:0]        s1_speed_r;
  logic [GAP_W-1:0]          s1_gap_r;
  logic                      s1_pres_r;

  // stage 2: travel term, speed after response, second products
  logic                      s2_v_r;
  logic [SUM_W-1:0]          s2_t1_r;
  logic [W_W-1:0]            s2_w_r;
  logic [PROD_RAR_W-1:0]     s2_rar_r;
  logic [2*CLOSE_W-1:0]      s2_cm2_r;
  logic [SPEED_W-1:0]        s2_speed_r;
  logic [GAP_W-1:0]          s2_gap_r;
  logic                      s2_pres_r;

  // stage 3: squared ego speed and reaction sum
  logic [2*W_W-1:0]          w_sq;
  logic                      s3_v_r;
  logic [QW-1:0]             s3_w2_r;
  logic [QW-1:0]             s3_cm2_r;
  logic [SUM_W-1:0]          s3_pos_r;
  logic [SPEED_W-1:0]        s3_speed_r;
  logic [GAP_W-1:0]          s3_gap_r;
  logic                      s3_pres_r;

  assign en3      = !s3_v_r || dn_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign up_ready = en1;

  assign close = $signed({2'b00, up_item.own_speed})
               + (SPEED_W+2)'(up_item.lead_rel_speed);
  assign close_mag = close[SPEED_W+1] ? CLOSE_W'(-close) : CLOSE_W'(close);
  assign w_sq = s2_w_r * s2_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= up_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_rv_r    <= PROD_RV_W'(resp_time) * PROD_RV_W'(up_item.own_speed);
      s1_ra_r    <= PROD_RA_W'(resp_time) * PROD_RA_W'(max_accel);
      s1_cm_r    <= close_mag;
      s1_speed_r <= up_item.own_speed;
      s1_gap_r   <= up_item.lead_gap;
      s1_pres_r  <= up_item.lead_present;
    end
    if (en2) begin
      s2_t1_r    <= SUM_W'(s1_rv_r >> FRAC_BITS);
      s2_w_r     <= W_W'(s1_speed_r) + W_W'(s1_ra_r >> FRAC_BITS);
      s2_rar_r   <= PROD_RAR_W'(s1_ra_r) * PROD_RAR_W'(resp_time);
      s2_cm2_r   <= (2*CLOSE_W)'(s1_cm_r) * (2*CLOSE_W)'(s1_cm_r);
      s2_speed_r <= s1_speed_r;
      s2_gap_r   <= s1_gap_r;
      s2_pres_r  <= s1_pres_r;
    end
    if (en3) begin
      s3_w2_r    <= QW'(w_sq);
      s3_cm2_r   <= QW'(s2_cm2_r);
      s3_pos_r   <= s2_t1_r + SUM_W'(s2_rar_r >> (2*FRAC_BITS + 1));
      s3_speed_r <= s2_speed_r;
      s3_gap_r   <= s2_gap_r;
      s3_pres_r  <= s2_pres_r;
    end
  end

  assign dn_valid    = s3_v_r;
  assign dn_ego_sq   = s3_w2_r;
  assign dn_close_sq = s3_cm2_r;
  assign dn_pos      = s3_pos_r;
  assign dn_speed    = s3_speed_r;
  assign dn_gap      = s3_gap_r;
  assign dn_present  = s3_pres_r;

endmodule

[rtl/rgsp_div_pipe.sv]
// rgsp_div_pipe: pipelined restoring divider, several lanes in lockstep,
// DIV_STEP quotient bits per stage, side data carried along; uses rgsp_pkg

module rgsp_div_pipe import rgsp_pkg::*; #(
  parameter int QW     = 34,
  parameter int DW     = DVS_W,
  parameter int LANES  = 2,
  parameter int STEP   = DIV_STEP,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DW-1:0]     divisor   [LANES],
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [QW-1:0]     dividend  [LANES],
  input  logic [SIDE_W-1:0] up_side,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [QW-1:0]     quotient  [LANES],
  output logic [SIDE_W-1:0] dn_side
);

  // QW is a multiple of STEP
  localparam int NSTG = QW / STEP;

  logic [NSTG-1:0]   v_r;
  logic [NSTG:0]     en;
  logic [NSTG-1:0]   v_in;
  logic [SIDE_W-1:0] side_r    [NSTG];
  logic [SIDE_W-1:0] side_in   [NSTG];
  logic [QW-1:0]     work_r    [NSTG][LANES];
  logic [DW-1:0]     rem_r     [NSTG][LANES];
  logic [QW-1:0]     work_in   [NSTG][LANES];
  logic [DW-1:0]     rem_in    [NSTG][LANES];
  logic [QW-1:0]     work_nxt  [NSTG][LANES];
  logic [DW-1:0]     rem_nxt   [NSTG][LANES];

  always_comb begin
    en[NSTG] = dn_ready;
    for (int s = NSTG - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  always_comb begin
    v_in[0]    = up_valid;
    side_in[0] = up_side;
    for (int l = 0; l < LANES; l++) begin
      work_in[0][l] = dividend[l];
      rem_in[0][l]  = '0;
    end
    for (int s = 1; s < NSTG; s++) begin
      v_in[s]    = v_r[s-1];
      side_in[s] = side_r[s-1];
      for (int l = 0; l < LANES; l++) begin
        work_in[s][l] = work_r[s-1][l];
        rem_in[s][l]  = rem_r[s-1][l];
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_comb begin
    logic [QW-1:0] wk;
    logic [DW-1:0] rm;
    logic [DW:0]   sh;
    logic          qb;
    for (int s = 0; s < NSTG; s++) begin
      for (int l = 0; l < LANES; l++) begin
        wk = work_in[s][l];
        rm = rem_in[s][l];
        for (int k = 0; k < STEP; k++) begin
          sh = {rm, wk[QW-1]};
          qb = (sh >= {1'b0, divisor[l]});
          if (qb) begin
            sh = sh - {1'b0, divisor[l]};
          end
          rm = sh[DW-1:0];
          wk = {wk[QW-2:0], qb};
        end
        work_nxt[s][l] = wk;
        rem_nxt[s][l]  = rm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (en[s]) v_r[s] <= v_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (en[s]) begin
        side_r[s] <= side_in[s];
        for (int l = 0; l < LANES; l++) begin
          work_r[s][l] <= work_nxt[s][l];
          rem_r[s][l]  <= rem_nxt[s][l];
        end
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NSTG-1];
  assign dn_side  = side_r[NSTG-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quotient[l] = work_r[NSTG-1][l];
    end
  end

endmodule

[rtl/rgsp_band_sel.sv]
// rgsp_band_sel: three stages that combine the distance terms, clamp the
// safe gap, pick the band and form the set speed; depends on rgsp_pkg

module rgsp_band_sel import rgsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [CAP_W-1:0]                 speed_cap,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic [quot_width(FRAC_BITS)-1:0] ego_brk,
  input  logic [quot_width(FRAC_BITS)-1:0] lead_brk,
  input  logic [quot_width(FRAC_BITS)+1:0] pos,
  input  logic [SPEED_W-1:0]               speed,
  input  logic [GAP_W-1:0]                 gap,
  input  logic                             present,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output out_item_t                        dn_item
);

  localparam int QW    = quot_width(FRAC_BITS);
  localparam int SUM_W = QW + 2;
  localparam int CW    = GAP_W + 4;
  localparam int SET_W = ((SPEED_W + 1 > FRAC_BITS + 2) ? SPEED_W + 1 : FRAC_BITS + 2) + 1;

  localparam logic [SUM_W-1:0] FLOOR_GAP = SUM_W'(5 << FRAC_BITS);
  localparam logic [SUM_W-1:0] MAX_GAP   = SUM_W'({GAP_W{1'b1}});

  localparam logic signed [SET_W-1:0] D_UP    = SET_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [SET_W-1:0] D_HOLD  = '0;
  localparam logic signed [SET_W-1:0] D_DOWN  = -D_UP;
  localparam logic signed [SET_W-1:0] D_WARN  = -(SET_W'((5 << FRAC_BITS) / 4));
  localparam logic signed [SET_W-1:0] D_EMERG = -(SET_W'(5 << (FRAC_BITS - 1)));

  logic en1, en2, en3;

  logic               b1_v_r;
  logic [SUM_W-1:0]   b1_total_r;
  logic [QW-1:0]      b1_t4_r;
  logic [SPEED_W-1:0] b1_speed_r;
  logic [GAP_W-1:0]   b1_gap_r;
  logic               b1_pres_r;

  logic [SUM_W-1:0]   diff;
  logic [GAP_W-1:0]   safe_clamped;
  logic               b2_v_r;
  logic [GAP_W-1:0]   b2_safe_r;
  logic [SPEED_W-1:0] b2_speed_r;
  logic [GAP_W-1:0]   b2_gap_r;
  logic               b2_pres_r;

  logic [CW-1:0]           g10, g2, g4, s9, s11, s1;
  logic [BAND_W-1:0]       band;
  logic signed [SET_W-1:0] delta;
  logic signed [SET_W-1:0] set_raw;
  logic [SPEED_W-1:0]      set_speed;
  logic                    b3_v_r;
  out_item_t               b3_item_r;

  assign en3      = !b3_v_r || dn_ready;
  assign en2      = !b2_v_r || en3;
  assign en1      = !b1_v_r || en2;
  assign up_ready = en1;

  // stage 2: lead braking removed, clamp to floor and field max
  always_comb begin
    if (SUM_W'(b1_t4_r) >= b1_total_r) begin
      diff = '0;
    end else begin
      diff = b1_total_r - SUM_W'(b1_t4_r);
    end
    priority if (diff < FLOOR_GAP) begin
      safe_clamped = GAP_W'(FLOOR_GAP);
    end else if (diff > MAX_GAP) begin
      safe_clamped = GAP_W'(MAX_GAP);
    end else begin
      safe_clamped = GAP_W'(diff);
    end
  end

  // stage 3: band by exact ratio compares, then set speed
  assign g10 = CW'(b2_gap_r) * CW'(10);
  assign g2  = CW'(b2_gap_r) << 1;
  assign g4  = CW'(b2_gap_r) << 2;
  assign s1  = CW'(b2_safe_r);
  assign s9  = CW'(b2_safe_r) * CW'(9);
  assign s11 = CW'(b2_safe_r) * CW'(11);

  always_comb begin
    priority if (!b2_pres_r) begin
      band  = BAND_NO_LEAD;
      delta = D_UP;
    end else if (g10 >= s11) begin
      band  = BAND_SAFE;
      delta = D_UP;
    end else if (g10 > s9) begin
      band  = BAND_HOLD;
      delta = D_HOLD;
    end else if (g2 >= s1) begin
      band  = BAND_BRAKE;
      delta = D_DOWN;
    end else if (g4 >= s1) begin
      band  = BAND_WARN;
      delta = D_WARN;
    end else begin
      band  = BAND_EMERG;
      delta = D_EMERG;
    end
    set_raw = $signed(SET_W'(b2_speed_r)) + delta;
    priority if (set_raw > $signed(SET_W'(speed_cap))) begin
      set_speed = speed_cap;
    end else if (set_raw < 0) begin
      set_speed = '0;
    end else begin
      set_speed = SPEED_W'(set_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else begin
      if (en1) b1_v_r <= up_valid;
      if (en2) b2_v_r <= b1_v_r;
      if (en3) b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      b1_total_r <= pos + SUM_W'(ego_brk);
      b1_t4_r    <= lead_brk;
      b1_speed_r <= speed;
      b1_gap_r   <= gap;
      b1_pres_r  <= present;
    end
    if (en2) begin
      b2_safe_r  <= b1_pres_r ? safe_clamped : '0;
      b2_speed_r <= b1_speed_r;
      b2_gap_r   <= b1_gap_r;
      b2_pres_r  <= b1_pres_r;
    end
    if (en3) begin
      b3_item_r.target_speed <= set_speed;
      b3_item_r.safe_gap     <= b2_safe_r;
      b3_item_r.band         <= band;
    end
  end

  assign dn_valid = b3_v_r;
  assign dn_item  = b3_item_r;

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for rss_gap_speed_planner_unit, with random flow control
// depends on rgsp_pkg, rgsp_stream_if and the rss_gap_speed_planner_unit rtl

module tb_top;
  import rgsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 2;
  // request-to-result latency of the planner pipeline
  localparam int PIPE_LAT = 6 + quot_width(FRAC_BITS_DEF) / 2;
  // quiet cycles after the last result, before a register write or the end
  localparam int SETTLE_CYCLES = PIPE_LAT + 10;
  // long output hold-off used to back the pipeline up into the input
  localparam int HOLD_CYCLES = 300;
  // cycles without any handshake or write before the run is called hung
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 10;
  localparam int REQS_PER_PHASE = 88;
  localparam longint unsigned GAP_TOP = (64'd1 << GAP_W) - 1;

  // one row of the directed table: the request and, where typed in, its result
  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  // every row runs at reset register values, where a stopped
  // ego car behind a stopped lead needs 384 (1.5 m), so the 5 m floor (1280) wins
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // no lead: accelerate, safe gap reads zero
    '{'{16'd0,     16'sd0,      20'd0,       1'b0}, 1'b1, '{16'd128,  20'd0,    BAND_NO_LEAD}},
    '{'{16'd65535, -16'sd32768, 20'hFFFFF,   1'b0}, 1'b1, '{16'd7680, 20'd0,    BAND_NO_LEAD}},
    '{'{16'd7600,  16'sd32767,  20'd12345,   1'b0}, 1'b1, '{16'd7680, 20'd0,    BAND_NO_LEAD}},
    // floored safe gap, walk every band edge
    '{'{16'd0,     16'sd0,      20'hFFFFF,   1'b1}, 1'b1, '{16'd128,  20'd1280, BAND_SAFE}},
    '{'{16'd0,     16'sd0,      20'd1408,    1'b1}, 1'b1, '{16'd128,  20'd1280, BAND_SAFE}},
    '{'{16'd0,     16'sd0,      20'd1407,    1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_HOLD}},
    '{'{16'd0,     16'sd0,      20'd1280,    1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_HOLD}},
    '{'{16'd0,     16'sd0,      20'd1153,    1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_HOLD}},
    '{'{16'd0,     16'sd0,      20'd1152,    1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_BRAKE}},
    '{'{16'd0,     16'sd0,      20'd640,     1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_BRAKE}},
    '{'{16'd0,     16'sd0,      20'd639,     1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_WARN}},
    '{'{16'd0,     16'sd0,      20'd320,     1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_WARN}},
    '{'{16'd0,     16'sd0,      20'd319,     1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_EMERG}},
    '{'{16'd0,     16'sd0,      20'd0,       1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_EMERG}},
    // lead braking term swamps the ego terms, difference clips at zero then floors
    '{'{16'd0,     16'sd32767,  20'd1408,    1'b1}, 1'b1, '{16'd128,  20'd1280, BAND_SAFE}},
    '{'{16'd0,     -16'sd32768, 20'd0,       1'b1}, 1'b1, '{16'd0,    20'd1280, BAND_EMERG}},
    // from here on the predictor works the numbers out
    '{'{16'd65535, 16'sd0,      20'hFFFFF,   1'b1}, 1'b0, '0},
    '{'{16'd65535, -16'sd32768, 20'd0,       1'b1}, 1'b0, '0},
    '{'{16'd65535, 16'sd32767,  20'd500000,  1'b1}, 1'b0, '0},
    '{'{16'd640,   -16'sd640,   20'd50000,   1'b1}, 1'b0, '0},
    '{'{16'd5000,  16'sd100,    20'd20000,   1'b1}, 1'b0, '0},
    '{'{16'd20000, -16'sd3000,  20'd100000,  1'b1}, 1'b0, '0},
    '{'{16'd639,   16'sd0,      20'd0,       1'b1}, 1'b0, '0},
    '{'{16'd7700,  16'sd0,      20'hFFFFF,   1'b1}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rgsp_stream_if #(.payload_t(in_item_t))  req_ch ();
  rgsp_stream_if #(.payload_t(out_item_t)) res_ch ();

  rss_gap_speed_planner_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_s      (req_ch),
    .out_s     (res_ch)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // bench copy of the register file, updated on every write
  cfg_regs_t plan_regs;
  // results still owed by the block, oldest first
  out_item_t planned_q [$];
  int unsigned n_fail;
  int unsigned quiet_cycles;
  // flow-control knobs: tx_idle for the request side, rx_idle and park_results for the result side
  bit tx_idle;
  bit rx_idle;
  bit park_results;

  wire req_fire = req_ch.valid && req_ch.ready;
  wire res_fire = res_ch.valid && res_ch.ready;

  // set speed, safe gap and band the block must produce for one request
  function automatic out_item_t plan_speed(input in_item_t it);
    longint unsigned one, v, g, rt, ac, bn, bx;
    longint unsigned t1, t2, w, t3, cm, t4, pos, sg;
    longint closing, step, setp, capv;
    out_item_t res;
    one = 64'd1 << FRAC_BITS_DEF;
    v = it.own_speed;
    g = it.lead_gap;
    rt = plan_regs.response_time;
    ac = plan_regs.max_accel;
    // zero braking registers behave as one
    bn = (plan_regs.min_brake == '0) ? 64'd1 : longint'(plan_regs.min_brake);
    bx = (plan_regs.max_brake == '0) ? 64'd1 : longint'(plan_regs.max_brake);
    capv = plan_regs.speed_cap;
    sg = 0;
    if (!it.lead_present) begin
      res.band = BAND_NO_LEAD;
      step = one / 2;
    end else begin
      // each term floors on its own
      t1 = (rt * v) >> FRAC_BITS_DEF;
      t2 = (ac * rt * rt) / (2 * one * one);
      w = v + ((rt * ac) >> FRAC_BITS_DEF);
      t3 = (w * w) / (2 * bn);
      closing = $signed(v) + longint'($signed(it.lead_rel_speed));
      cm = (closing < 0) ? -closing : closing;
      t4 = (cm * cm) / (2 * bx);
      pos = t1 + t2 + t3;
      sg = (t4 >= pos) ? 64'd0 : pos - t4;
      if (sg < 5 * one) sg = 5 * one;
      if (sg > GAP_TOP) sg = GAP_TOP;
      // 1.1x and 0.9x compared exactly in tenths
      if (10 * g >= 11 * sg) begin
        res.band = BAND_SAFE;
        step = one / 2;
      end else if (10 * g > 9 * sg) begin
        res.band = BAND_HOLD;
        step = 0;
      end else if (2 * g >= sg) begin
        res.band = BAND_BRAKE;
        step = -(one / 2);
      end else if (4 * g >= sg) begin
        res.band = BAND_WARN;
        step = -((5 * one) / 4);
      end else begin
        res.band = BAND_EMERG;
        step = -((5 * one) / 2);
      end
    end
    setp = $signed(v) + step;
    if (setp > capv) setp = capv;
    if (setp < 0) setp = 0;
    res.target_speed = setp[SPEED_W-1:0];
    res.safe_gap = sg[GAP_W-1:0];
    return res;
  endfunction

  // gap aimed at a band edge of the given safe gap, or somewhere around it
  function automatic logic [GAP_W-1:0] gap_near(input longint unsigned sg);
    longint unsigned g;
    case ($urandom_range(0, 5))
      0: g = (sg * $urandom_range(0, 220)) / 100;
      1: g = (11 * sg + 9) / 10;  // first safe gap
      2: g = (9 * sg) / 10 + 1;   // first hold gap
      3: g = (sg + 1) / 2;        // first brake gap
      4: g = (sg + 3) / 4;        // first warn gap
      default: g = $urandom_range(0, GAP_TOP);
    endcase
    // step one below the edge half the time
    if (g != 0 && $urandom_range(0, 1) == 1) g = g - 1;
    if (g > GAP_TOP) g = GAP_TOP;
    return g[GAP_W-1:0];
  endfunction

  // mostly a lead in traffic with the gap near a band edge, some noise
  function automatic in_item_t random_request();
    in_item_t it;
    out_item_t probe;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    it.own_speed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                               : $urandom_range(0, 12800);
    it.lead_rel_speed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                                    : $urandom_range(0, 8000) - 4000;
    it.lead_gap = $urandom_range(0, GAP_TOP);
    it.lead_present = 1'b1;
    if (kind == 0) begin
      it.lead_present = $urandom_range(0, 1);
    end else if (kind == 1) begin
      it.lead_present = 1'b0;
    end else begin
      probe = plan_speed(it);
      it.lead_gap = gap_near(probe.safe_gap);
    end
    return it;
  endfunction

  // offer one request after the given idle gap and log its result once taken
  task automatic send_request(input in_item_t it, input out_item_t want,
                              input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.payload <= it;
    do @(posedge clk); while (!req_ch.ready);
    planned_q.push_back(want);
  endtask

  // stop offering and wait until every result is back and the pipe is quiet
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (planned_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_RESPONSE_TIME: plan_regs.response_time = val[REG_W-1:0];
      CFG_MAX_ACCEL:     plan_regs.max_accel     = val[REG_W-1:0];
      CFG_MIN_BRAKE:     plan_regs.min_brake     = val[REG_W-1:0];
      CFG_MAX_BRAKE:     plan_regs.max_brake     = val[REG_W-1:0];
      CFG_SPEED_CAP:     plan_regs.speed_cap     = val[CAP_W-1:0];
      default: ;  // unused indexes change nothing
    endcase
  endtask

  // load a full setting; the pipe must already be empty
  task automatic load_setting(input logic [CFG_DATA_W-1:0] rt, input logic [CFG_DATA_W-1:0] ac,
                              input logic [CFG_DATA_W-1:0] bn, input logic [CFG_DATA_W-1:0] bx,
                              input logic [CFG_DATA_W-1:0] cap);
    write_reg(CFG_RESPONSE_TIME, rt);
    write_reg(CFG_MAX_ACCEL, ac);
    write_reg(CFG_MIN_BRAKE, bn);
    write_reg(CFG_MAX_BRAKE, bx);
    write_reg(CFG_SPEED_CAP, cap);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random requests, with idling switched on and off in stretches
  task automatic run_random(input int unsigned count);
    in_item_t it;
    int unsigned gap;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 16 == 0) begin
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      it = random_request();
      gap = tx_idle ? $urandom_range(0, 17) : 0;
      send_request(it, plan_speed(it), gap);
    end
  endtask

  // result side: random stalls per result, plus one long park on request
  initial begin : result_sink
    int unsigned stall;
    res_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (park_results) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        park_results = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 17) : 0;
      if (stall != 0) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // compare each result with the oldest planned one
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && res_fire) begin
      if (planned_q.size() == 0) begin
        $display("%0t ns: result with none expected, actual %h", $time, res_ch.payload);
        n_fail++;
      end else begin
        want = planned_q.pop_front();
        if (res_ch.payload.target_speed !== want.target_speed) begin
          $display("%0t ns: target_speed expected %0d actual %0d", $time,
                   want.target_speed, res_ch.payload.target_speed);
          n_fail++;
        end
        if (res_ch.payload.safe_gap !== want.safe_gap) begin
          $display("%0t ns: safe_gap expected %0d actual %0d", $time,
                   want.safe_gap, res_ch.payload.safe_gap);
          n_fail++;
        end
        if (res_ch.payload.band !== want.band) begin
          $display("%0t ns: band expected %0d actual %0d", $time,
                   want.band, res_ch.payload.band);
          n_fail++;
        end
      end
    end
  end

  // hang detector: no request, result or write for too long
  always @(posedge clk) begin
    if (!rst_n || req_fire || res_fire || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rss_gap_speed_planner_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    in_item_t it;
    out_item_t want;
    logic [CFG_DATA_W-1:0] rnd [5];
    n_fail = 0;
    quiet_cycles = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    park_results = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    plan_regs = '{RST_RESPONSE_TIME, RST_MAX_ACCEL, RST_MIN_BRAKE, RST_MAX_BRAKE,
                  RST_SPEED_CAP};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table at reset register values, typed results where obvious
    rx_idle = 1'b1;
    for (int r = 0; r < DIR_ROWS; r++) begin
      it = DIR_TAB[r].stim;
      want = DIR_TAB[r].typed ? DIR_TAB[r].want : plan_speed(it);
      send_request(it, want, $urandom_range(0, 3));
    end
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        // all-ones data: every register at its width limit, cap at full speed
        0: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // all zero: zero braking counts as one, set speed pinned at zero
        1: load_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: load_setting(16'd2560, 16'd1, 16'd1, 16'd2560, 16'hFFFF);
        3: load_setting(16'd0, 16'd2560, 16'd2560, 16'd1, 16'd7680);
        4: begin
          // writes past the last register must leave the setting alone
          load_setting(16'd256, 16'd300, 16'd1500, 16'd1500, 16'd12000);
          for (int k = CFG_SPEED_CAP + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(k, $urandom_range(0, 16'hFFFF));
          @(negedge clk);
          cfg_we <= 1'b0;
        end
        default: begin
          // random setting, the first four registers mostly in 1..2560, the cap anywhere
          for (int k = 0; k < 4; k++)
            rnd[k] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16'hFFFF)
                                                 : $urandom_range(1, 2560);
          rnd[4] = $urandom_range(0, 16'hFFFF);
          load_setting(rnd[0], rnd[1], rnd[2], rnd[3], rnd[4]);
        end
      endcase

      if (p == 2) begin
        // park the result side while requests keep coming back to back,
        // so the pipe fills and the input has to stall
        park_results = 1'b1;
        tx_idle = 1'b0;
        for (int k = 0; k < 100; k++) begin
          it = random_request();
          send_request(it, plan_speed(it), 0);
        end
        run_random(REQS_PER_PHASE - 100 > 0 ? REQS_PER_PHASE - 100 : 0);
      end else begin
        run_random(REQS_PER_PHASE);
      end
      drain_results();
    end

    if (n_fail == 0) begin
      $display("rss_gap_speed_planner_unit test passed");
    end else begin
      $display("rss_gap_speed_planner_unit test failed");
    end
    $finish;
  end

endmodule
